@@ hw/rtl/sli_pkg.sv @@
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and constants of the sorted list intersection core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sli_pkg;

    localparam int MAX_LISTS  = 8;
    localparam int LIST_DEPTH = 64;
    localparam int KEY_BITS   = 32;
    localparam int MASK_W     = 8;

    localparam int LIDX_W = $clog2(MAX_LISTS);
    localparam int POS_W  = $clog2(LIST_DEPTH);
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W = LIDX_W + POS_W;
    localparam int DEPTH  = MAX_LISTS * LIST_DEPTH;
    localparam int TREE_N = 1 << LIDX_W;

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [LIDX_W-1:0]   t_lane;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [ADDR_W-1:0]   t_addr;

    localparam t_cnt CNT_FULL = CNT_W'(LIST_DEPTH);

    localparam logic OP_APPEND  = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_EVAL,
        ST_STEP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic        operation;
        logic [2:0]  list_index;
        logic [31:0] key;
    } t_in_item;

    typedef struct packed {
        logic [31:0] match_key;
        logic        found;
        logic        last;
        logic        overflow;
    } t_out_item;

    typedef struct packed {
        logic  any;
        logic  same;
        t_lane idx;
        t_key  min;
    } t_eval;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_key  wdata;
        logic  re;
        t_addr raddr;
    } t_mem_req;

endpackage

`default_nettype wire

@@ hw/rtl/sli_store.sv @@
// ----------------------------------------------------------------------------
// sli_store
// Key store for all lists, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sli_store (
    input  wire                 i_clk,
    input  sli_pkg::t_mem_req   i_req,
    output sli_pkg::t_key       o_rdata
);
    import sli_pkg::*;

    t_key r_mem [DEPTH];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/sli_min_tree.sv @@
// ----------------------------------------------------------------------------
// sli_min_tree
// Compare tree over the list heads: smallest live head, its lane and
// whether all live heads hold the same key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sli_min_tree (
    input  sli_pkg::t_key             i_head [sli_pkg::MAX_LISTS],
    input  wire [sli_pkg::MAX_LISTS-1:0] i_live,
    output sli_pkg::t_eval            o_eval
);
    import sli_pkg::*;

    t_key  v  [2*TREE_N];
    logic  ok [2*TREE_N];
    t_lane ix [2*TREE_N];
    logic  take_r;
    logic  same;

    always_comb begin
        take_r = 1'b0;
        for (int k = 0; k < 2*TREE_N; k++) begin
            v[k]  = '0;
            ok[k] = 1'b0;
            ix[k] = '0;
        end
        for (int k = 0; k < MAX_LISTS; k++) begin
            v[TREE_N+k]  = i_head[k];
            ok[TREE_N+k] = i_live[k];
            ix[TREE_N+k] = LIDX_W'(k);
        end
        // ties go to the lower lane
        for (int k = TREE_N - 1; k >= 1; k--) begin
            take_r = ok[2*k+1] && (!ok[2*k] || (v[2*k+1] < v[2*k]));
            v[k]   = take_r ? v[2*k+1]  : v[2*k];
            ix[k]  = take_r ? ix[2*k+1] : ix[2*k];
            ok[k]  = ok[2*k] || ok[2*k+1];
        end
    end

    always_comb begin
        same = 1'b1;
        for (int i = 0; i < MAX_LISTS; i++) begin
            if (i_live[i] && (i_head[i] != v[1])) begin
                same = 1'b0;
            end
        end
    end

    assign o_eval.any  = ok[1];
    assign o_eval.same = same;
    assign o_eval.idx  = ix[1];
    assign o_eval.min  = v[1];

endmodule

`default_nettype wire

@@ hw/rtl/sorted_list_intersection_core.sv @@
// ----------------------------------------------------------------------------
// sorted_list_intersection_core
// Append: written while idle, next beat accepted in the following cycle.
// Compute with L live lists: heads load through the single store read port
// (FILL), are compared (EVAL) and advanced (STEP): a mismatch reloads one
// head, a match all L; FINISH gives the last result, directly if none live.
// Results leave as one-cycle strobes and cannot be stalled.
// Synchronous reset empties all lists, clears overflow, sets the mask to 255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_intersection_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  sli_pkg::t_in_item   i_item,
    output logic                o_res_strobe,
    output sli_pkg::t_out_item  o_result,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [7:0]           i_cfg_data
);
    import sli_pkg::*;

    t_state r_state, n_state;

    logic [MASK_W-1:0]    r_mask;
    logic                 r_ovf;
    t_cnt                 r_cnt  [MAX_LISTS];
    t_cnt                 r_pos  [MAX_LISTS];
    t_key                 r_last [MAX_LISTS];
    t_key                 r_head [MAX_LISTS];
    logic [MAX_LISTS-1:0] r_live;
    logic [MAX_LISTS-1:0] r_pend;
    logic                 r_rd_vld;
    t_lane                r_rd_lane;
    t_eval                r_eval;
    t_key                 r_hold_key;
    logic                 r_hold_vld;
    t_cnt                 r_nres;

    t_mem_req             mem_req;
    t_key                 rdata;
    t_eval                eval;

    logic                 accept;
    logic                 lane_ok;
    t_lane                lane;
    t_key                 in_key;
    t_cnt                 cur_cnt;
    logic                 app_drop;
    logic                 app_full;
    logic                 app_write;
    logic [MAX_LISTS-1:0] live0;
    t_lane                pick;
    logic [MAX_LISTS-1:0] adv;
    logic [MAX_LISTS-1:0] exhausted;
    logic                 step_stop;
    t_cnt                 nres_inc;

    sli_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    sli_min_tree u_tree (
        .i_head (r_head),
        .i_live (r_live),
        .o_eval (eval)
    );

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;

    // append checks
    always_comb begin
        lane_ok   = (32'(i_item.list_index) < 32'(MAX_LISTS));
        lane      = LIDX_W'(i_item.list_index);
        in_key    = KEY_BITS'(i_item.key);
        cur_cnt   = r_cnt[lane];
        app_drop  = !lane_ok || (in_key == '0) ||
                    ((cur_cnt != '0) && (in_key <= r_last[lane]));
        app_full  = (cur_cnt >= CNT_FULL);
        app_write = accept && (i_item.operation == OP_APPEND) && !app_drop && !app_full;
    end

    always_comb begin
        live0 = '0;
        for (int i = 0; i < MAX_LISTS && i < MASK_W; i++) begin
            live0[i] = r_mask[i] && (r_cnt[i] != '0);
        end
    end

    always_comb begin
        pick = '0;
        for (int i = MAX_LISTS - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                pick = LIDX_W'(i);
            end
        end
    end

    // head advance for one walk step
    always_comb begin
        for (int i = 0; i < MAX_LISTS; i++) begin
            adv[i]       = r_eval.same ? r_live[i] : (r_eval.idx == LIDX_W'(i));
            exhausted[i] = (CNT_W'(r_pos[i] + 1'b1) >= r_cnt[i]);
        end
        nres_inc  = CNT_W'(r_nres + 1'b1);
        step_stop = |(adv & exhausted) || (r_eval.same && (nres_inc >= CNT_FULL));
    end

    always_comb begin
        mem_req.we    = app_write;
        mem_req.waddr = {lane, cur_cnt[POS_W-1:0]};
        mem_req.wdata = in_key;
        mem_req.re    = (r_state == ST_FILL) && (r_pend != '0);
        mem_req.raddr = {pick, r_pos[pick][POS_W-1:0]};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_item.operation == OP_COMPUTE)) begin
                    n_state = (live0 == '0) ? ST_FINISH : ST_FILL;
                end
            end
            ST_FILL: begin
                if (r_pend == '0) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_STEP;
            end
            ST_STEP: begin
                n_state = step_stop ? ST_FINISH : ST_FILL;
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res_strobe       = 1'b0;
        o_result.match_key = 32'(r_hold_key);
        o_result.found     = 1'b1;
        o_result.last      = 1'b0;
        o_result.overflow  = r_ovf;
        case (r_state)
            ST_STEP: begin
                o_res_strobe = r_eval.same && r_hold_vld;
            end
            ST_FINISH: begin
                o_res_strobe  = 1'b1;
                o_result.last = 1'b1;
                if (!r_hold_vld) begin
                    o_result.match_key = '0;
                    o_result.found     = 1'b0;
                end
            end
            default: begin
                o_res_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mask     <= '1;
            r_ovf      <= 1'b0;
            r_live     <= '0;
            r_pend     <= '0;
            r_rd_vld   <= 1'b0;
            r_hold_vld <= 1'b0;
            r_nres     <= '0;
            for (int i = 0; i < MAX_LISTS; i++) begin
                r_cnt[i] <= '0;
                r_pos[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_rd_vld <= mem_req.re;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mask <= i_cfg_data;
            end
            if (accept && (i_item.operation == OP_APPEND) && !app_drop && app_full) begin
                r_ovf <= 1'b1;
            end
            if (app_write) begin
                r_cnt[lane] <= CNT_W'(cur_cnt + 1'b1);
            end
            if (accept && (i_item.operation == OP_COMPUTE)) begin
                r_live     <= live0;
                r_pend     <= live0;
                r_hold_vld <= 1'b0;
                r_nres     <= '0;
                for (int i = 0; i < MAX_LISTS; i++) begin
                    r_pos[i] <= '0;
                end
            end
            if (mem_req.re) begin
                r_pend[pick] <= 1'b0;
            end
            if (r_state == ST_STEP) begin
                for (int i = 0; i < MAX_LISTS; i++) begin
                    if (adv[i]) begin
                        r_pos[i] <= CNT_W'(r_pos[i] + 1'b1);
                    end
                end
                r_pend <= adv;
                if (r_eval.same) begin
                    r_hold_vld <= 1'b1;
                    r_nres     <= nres_inc;
                end
            end
            if (r_state == ST_FINISH) begin
                for (int i = 0; i < MAX_LISTS; i++) begin
                    r_cnt[i] <= '0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_lane <= pick;
        r_eval    <= eval;
        if (app_write) begin
            r_last[lane] <= in_key;
        end
        if (r_rd_vld) begin
            r_head[r_rd_lane] <= rdata;
        end
        if ((r_state == ST_STEP) && r_eval.same) begin
            r_hold_key <= r_eval.min;
        end
    end

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> busy)
        else $error("result strobe outside a compute");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_result.last) |=> !busy)
        else $error("compute still running after its last result");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (r_state == ST_IDLE))
        else $error("store written during a compute");

    a_result_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nres <= CNT_FULL))
        else $error("more results than the list depth");

endmodule

`default_nettype wire
